/* rtl/core/fofgd_pkg.sv */
// fofgd_pkg: shared widths, register map and coefficient table for the
// offset / fir / gain-divide filter. No dependencies.
package fofgd_pkg;

    localparam int X_W       = 17;  // offset-removed sample
    localparam int COEF_W    = 15;  // unsigned coefficient magnitude
    localparam int COEF_IW   = 6;   // coefficient slot index
    localparam int PROD_W    = 33;  // signed sample times signed coefficient
    localparam int ACC_W     = 40;  // accumulator, cannot overflow
    localparam int GAIN_W    = 31;
    localparam int DIV_CW    = 6;   // divider step counter

    localparam logic [GAIN_W-1:0] GAIN_RESET = GAIN_W'(262144);

    localparam logic REG_GAIN   = 1'b0;
    localparam logic REG_OFFSET = 1'b1;

    function automatic logic [COEF_W-1:0] coef(input logic [COEF_IW-1:0] k);
        logic [COEF_W-1:0] c;
        case (k)
            6'd0:    c = 15'd25615;
            6'd1:    c = 15'd26169;
            6'd2:    c = 15'd26569;
            6'd3:    c = 15'd26812;
            6'd4:    c = 15'd26893;
            6'd5:    c = 15'd26812;
            6'd6:    c = 15'd26569;
            6'd7:    c = 15'd26169;
            6'd8:    c = 15'd25615;
            6'd9:    c = 15'd24916;
            default: c = '0;
        endcase
        return c;
    endfunction

endpackage

/* rtl/core/fofgd_ram.sv */
// fofgd_ram: generic simple dual-port ram, one write and one registered read
// per cycle. No dependencies.
module fofgd_ram #(
    parameter int WIDTH = 17,
    parameter int DEPTH = 9
) (
    input  logic                                    i_clk,
    input  logic                                    i_we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                        i_wdata,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                        o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

/* rtl/core/fofgd_div.sv */
// fofgd_div: restoring serial divider, one quotient bit per cycle.
// Depends on fofgd_pkg for widths.
module fofgd_div
    import fofgd_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  logic [ACC_W-1:0]  i_dividend,
    input  logic [GAIN_W-1:0] i_divisor,
    output logic              o_done,
    output logic [ACC_W-1:0]  o_quotient
);

    logic [GAIN_W:0]   r_rem;
    logic [ACC_W-1:0]  r_quo;
    logic [GAIN_W-1:0] r_div;
    logic [DIV_CW-1:0] r_cnt;
    logic              r_busy;
    logic              r_done;

    logic [GAIN_W:0]   shifted;
    logic [GAIN_W+1:0] diff;
    logic              ge;

    assign shifted = {r_rem[GAIN_W-1:0], r_quo[ACC_W-1]};
    assign diff    = {1'b0, shifted} - {2'b00, r_div};
    assign ge      = ~diff[GAIN_W+1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= !i_start && r_busy && (r_cnt == DIV_CW'(1));
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= DIV_CW'(ACC_W);
                r_rem  <= '0;
                r_quo  <= i_dividend;
                r_div  <= i_divisor;
            end else if (r_busy) begin
                r_rem <= ge ? diff[GAIN_W:0] : shifted;
                r_quo <= {r_quo[ACC_W-2:0], ge};
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == DIV_CW'(1)) begin
                    r_busy <= 1'b0;
                end
            end
        end
    end

    assign o_done     = r_done;
    assign o_quotient = r_quo;

endmodule

/* rtl/core/fir_filter_offset_gain_divide.sv */
// fir_filter_offset_gain_divide: offset removal, direct-form fir over a ram
// delay line with one shared multiplier, serial gain division, saturation.
// Depends on fofgd_pkg, fofgd_ram and fofgd_div.
//
//  channel  | handshake               | payload
//  ---------+-------------------------+------------------------------
//  input    | i_in_valid / o_in_stall | i_raw_sample, i_start_block
//  output   | o_out_valid/ i_out_stall| o_filtered, o_clipped
//  config   | apb psel/penable/pready | paddr, pwdata, prdata
//
// one sample takes its taps in turn through the shared multiplier, then the drain and post
// states; when a result is due, the serial divider runs (one quotient bit a cycle) and
// the quotient is handed to the output register. warm-up samples finish after the
// multiplier pass. the input is stalled while a sample is in work; the output
// register lets the next sample enter while a result waits, and a finished sample
// holds in its last cycle while that register is full and stalled.
// synchronous active-low reset restores the register defaults and clears the
// history valid bits.
module fir_filter_offset_gain_divide
    import fofgd_pkg::*;
#(
    parameter int TAPS       = 10,
    parameter int SKIP_COUNT = 10
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  logic signed [15:0] i_raw_sample,
    input  logic               i_start_block,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output logic signed [15:0] o_filtered,
    output logic               o_clipped,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [2:0]         paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready
);

    localparam int HIST_LEN = TAPS - 1;
    localparam int PW       = (HIST_LEN > 1) ? $clog2(HIST_LEN) : 1;
    localparam int KW       = $clog2(TAPS);
    localparam int WW       = (SKIP_COUNT > 0) ? $clog2(SKIP_COUNT + 1) : 1;

    typedef enum logic [2:0] {
        S_IDLE, S_MAC, S_DRAIN1, S_DRAIN2, S_POST, S_DIV, S_OUT
    } t_state;

    t_state r_state, n_state;

    logic [GAIN_W-1:0]       r_gain;
    logic signed [15:0]      r_offset;
    logic [HIST_LEN-1:0]     r_hvalid;
    logic [PW-1:0]           r_head;
    logic [PW-1:0]           r_pos;
    logic [PW-1:0]           r_addr;
    logic [WW-1:0]           r_warm;
    logic [KW-1:0]           r_k;
    logic signed [X_W-1:0]   r_x;
    logic                    r_d_vld;
    logic                    r_d_isx;
    logic                    r_d_hv;
    logic [KW-1:0]           r_d_k;
    logic                    r_p_vld;
    logic signed [PROD_W-1:0] r_prod;
    logic signed [ACC_W-1:0] r_acc;
    logic                    r_neg;
    logic                    r_ovalid;
    logic signed [15:0]      r_filtered;
    logic                    r_clipped;

    logic                    in_xfer, out_free, cfg_wr, warm_done, div_start, div_done;
    logic [PW-1:0]           new_pos;
    logic [X_W-1:0]          ram_rdata;
    logic signed [X_W-1:0]   operand;
    logic signed [PROD_W-1:0] prod_c;
    logic [ACC_W-1:0]        acc_mag;
    logic [ACC_W-1:0]        quo;
    logic [GAIN_W-1:0]       divisor;
    logic                    sat;
    logic signed [15:0]      sat_val;

    assign in_xfer   = i_in_valid && (r_state == S_IDLE);
    assign o_in_stall = (r_state != S_IDLE);
    assign out_free  = !r_ovalid || !i_out_stall;
    assign cfg_wr    = psel && penable && pwrite && pready;
    assign pready    = 1'b1;
    assign prdata    = (paddr[2] == REG_OFFSET) ? {{16{r_offset[15]}}, r_offset}
                                                : {1'b0, r_gain};
    assign warm_done = !(r_warm < WW'(SKIP_COUNT));
    assign div_start = (r_state == S_POST) && warm_done;
    assign new_pos   = (r_pos == '0) ? PW'(HIST_LEN - 1) : r_pos - 1'b1;

    assign operand = r_d_isx ? r_x : (r_d_hv ? $signed(ram_rdata) : '0);
    assign prod_c  = PROD_W'(operand) * PROD_W'($signed({1'b0, coef(COEF_IW'(r_d_k))}));
    assign acc_mag = r_acc[ACC_W-1] ? ACC_W'(-r_acc) : ACC_W'(r_acc);
    assign divisor = (r_gain == '0) ? GAIN_W'(1) : r_gain;

    assign sat     = r_neg ? (quo > ACC_W'(32768)) : (quo > ACC_W'(32767));
    assign sat_val = sat ? (r_neg ? 16'sh8000 : 16'sh7fff)
                         : (r_neg ? $signed(-quo[15:0]) : $signed(quo[15:0]));

    fofgd_ram #(
        .WIDTH (X_W),
        .DEPTH (HIST_LEN)
    ) u_hist (
        .i_clk   (i_clk),
        .i_we    (r_state == S_DRAIN1),
        .i_waddr (new_pos),
        .i_wdata (r_x),
        .i_raddr (r_addr),
        .o_rdata (ram_rdata)
    );

    fofgd_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (acc_mag),
        .i_divisor  (divisor),
        .o_done     (div_done),
        .o_quotient (quo)
    );

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE:   if (in_xfer) n_state = S_MAC;
            S_MAC:    if (r_k == KW'(TAPS - 1)) n_state = S_DRAIN1;
            S_DRAIN1: n_state = S_DRAIN2;
            S_DRAIN2: n_state = S_POST;
            S_POST:   n_state = warm_done ? S_DIV : S_IDLE;
            S_DIV:    if (div_done) n_state = S_OUT;
            S_OUT:    if (out_free) n_state = S_IDLE;
            default:  n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_gain   <= GAIN_RESET;
            r_offset <= '0;
            r_hvalid <= '0;
            r_head   <= '0;
            r_warm   <= '0;
            r_ovalid <= 1'b0;
            r_d_vld  <= 1'b0;
            r_p_vld  <= 1'b0;
        end else begin
            r_state <= n_state;

            if (cfg_wr) begin
                if (paddr[2] == REG_GAIN) begin
                    r_gain <= pwdata[GAIN_W-1:0];
                end else begin
                    r_offset <= pwdata[15:0];
                end
            end

            // accept: offset removal and block restart
            if (in_xfer) begin
                r_x   <= $signed({i_raw_sample[15], i_raw_sample})
                       - $signed({r_offset[15], r_offset});
                r_k   <= '0;
                r_acc <= '0;
                if (i_start_block) begin
                    r_hvalid <= '0;
                    r_head   <= '0;
                    r_warm   <= '0;
                    r_pos    <= '0;
                    r_addr   <= '0;
                end else begin
                    r_pos  <= r_head;
                    r_addr <= r_head;
                end
            end

            // issue stage: tap 0 takes the new sample, the rest read the delay line
            r_d_vld <= (r_state == S_MAC);
            r_d_isx <= (r_k == '0);
            r_d_k   <= r_k;
            r_d_hv  <= r_hvalid[r_addr];
            if (r_state == S_MAC) begin
                r_k <= r_k + 1'b1;
                if (r_k != '0) begin
                    r_addr <= (r_addr == PW'(HIST_LEN - 1)) ? '0 : r_addr + 1'b1;
                end
            end

            // multiply and accumulate stages
            r_p_vld <= r_d_vld;
            r_prod  <= prod_c;
            if (r_p_vld) begin
                r_acc <= r_acc + {{(ACC_W-PROD_W){r_prod[PROD_W-1]}}, r_prod};
            end

            if (r_state == S_DRAIN1) begin
                r_hvalid[new_pos] <= 1'b1;
                r_head            <= new_pos;
            end

            if (r_state == S_POST) begin
                r_neg <= r_acc[ACC_W-1];
                if (!warm_done) begin
                    r_warm <= r_warm + 1'b1;
                end
            end

            if ((r_state == S_OUT) && out_free) begin
                r_ovalid   <= 1'b1;
                r_filtered <= sat_val;
                r_clipped  <= sat;
            end else if (r_ovalid && !i_out_stall) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    assign o_out_valid = r_ovalid;
    assign o_filtered  = r_filtered;
    assign o_clipped   = r_clipped;

endmodule

/* bench/tb_top.sv */
`timescale 1ns / 1ps
// tb_top: self-checking bench for fir_filter_offset_gain_divide, with its own
// tap-by-tap filter predictor and a queue of expected results.
// Depends on fofgd_pkg and the filter rtl.
module tb_top;
    import fofgd_pkg::*;

    localparam int N_TAPS       = 10;
    localparam int DELAY_LEN    = N_TAPS - 1;
    localparam int SKIP_COUNT   = 10;
    localparam int DRAIN_CYCLES = 80;

    localparam longint FIR_COEF [N_TAPS] = '{
        25615, 26169, 26569, 26812, 26893, 26812, 26569, 26169, 25615, 24916
    };

    typedef struct packed {
        logic signed [15:0] filtered;
        logic               clipped;
    } t_fir_result;

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               in_valid = 1'b0;
    logic               in_stall;
    logic signed [15:0] raw_sample = '0;
    logic               start_block = 1'b0;
    logic               out_valid;
    logic               out_stall = 1'b0;
    logic signed [15:0] filtered;
    logic               clipped;
    logic               psel = 1'b0;
    logic               penable = 1'b0;
    logic               pwrite = 1'b0;
    logic [2:0]         paddr = '0;
    logic [31:0]        pwdata = '0;
    logic [31:0]        prdata;
    logic               pready;

    // predictor state and register copies
    logic signed [16:0] delay_line [DELAY_LEN];
    int                 newest_idx = 0;
    int                 warmup_seen = 0;
    logic [30:0]        gain_cfg = GAIN_RESET;
    logic signed [15:0] offset_cfg = '0;

    t_fir_result        expected_results [$];
    int                 mismatches = 0;
    bit                 steady = 1'b0;

    fir_filter_offset_gain_divide #(
        .TAPS       (N_TAPS),
        .SKIP_COUNT (SKIP_COUNT)
    ) u_dut (
        .i_clk         (clk),
        .i_rst_n       (rst_n),
        .i_in_valid    (in_valid),
        .o_in_stall    (in_stall),
        .i_raw_sample  (raw_sample),
        .i_start_block (start_block),
        .o_out_valid   (out_valid),
        .i_out_stall   (out_stall),
        .o_filtered    (filtered),
        .o_clipped     (clipped),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    always begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    initial begin
        foreach (delay_line[k]) delay_line[k] = '0;
    end

    function automatic void filter_sample(input logic signed [15:0] raw, input logic start);
        logic signed [16:0] x;
        longint             acc;
        longint             quot;
        longint             divisor;
        int                 pos;
        t_fir_result        res;
        if (start) begin
            foreach (delay_line[k]) delay_line[k] = '0;
            newest_idx = 0;
            warmup_seen = 0;
        end
        x = raw - offset_cfg;
        pos = newest_idx % DELAY_LEN;
        acc = longint'(x) * FIR_COEF[0];
        for (int k = 0; k < DELAY_LEN; k++)
            acc += longint'(delay_line[(k + pos) % DELAY_LEN]) * FIR_COEF[k + 1];
        pos = (pos == 0) ? DELAY_LEN - 1 : pos - 1;
        delay_line[pos] = x;
        newest_idx = pos;
        if (warmup_seen < SKIP_COUNT) begin
            warmup_seen++;
            return;
        end
        divisor = (gain_cfg == 0) ? 64'sd1 : longint'(gain_cfg);
        quot = acc / divisor;
        res.clipped = 1'b0;
        if (quot > 32767) begin
            quot = 32767;
            res.clipped = 1'b1;
        end else if (quot < -32768) begin
            quot = -32768;
            res.clipped = 1'b1;
        end
        res.filtered = 16'(quot);
        expected_results.push_back(res);
    endfunction

    task automatic write_reg(input logic [2:0] addr, input logic [31:0] data);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= addr;
        pwdata <= data;
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        case (addr)
            {REG_GAIN, 2'b00}:   gain_cfg = data[30:0];
            {REG_OFFSET, 2'b00}: offset_cfg = data[15:0];
            default: ;
        endcase
        @(posedge clk);
    endtask

    task automatic send_sample(input logic signed [15:0] raw, input logic start);
        while (!steady && $urandom_range(99) < 14) begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        raw_sample <= raw;
        start_block <= start;
        do @(posedge clk); while (in_stall);
        filter_sample(raw, start);
    endtask

    task automatic wait_idle();
        in_valid <= 1'b0;
        while (expected_results.size() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    // reset defaults, suppressed warm-up outputs, extremes of the sample
    task automatic test_block_warmup();
        for (int i = 0; i < 12; i++)
            send_sample((i % 2 == 0) ? 16'sh7fff : 16'sh8000, i == 0);
        wait_idle();
    endtask

    // zero divisor falls back to one, so the sum itself saturates
    task automatic test_zero_divisor();
        write_reg({REG_GAIN, 2'b00}, 32'd0);
        write_reg({REG_OFFSET, 2'b00}, 32'hffff_8000);
        for (int i = 0; i < 11; i++)
            send_sample(16'sh7fff, i == 0);
        wait_idle();
    endtask

    // offset-removed sample keeps all 17 bits, no wrap at 16
    task automatic test_offset_full_width();
        write_reg({REG_GAIN, 2'b00}, 32'd1048576);
        send_sample(16'sh7fff, 1'b0);
        send_sample(16'sh7fff, 1'b0);
        wait_idle();
    endtask

    task automatic test_random_blocks(input logic [30:0] gain, input logic signed [15:0] offset,
                                      input bit no_gaps, input int n_items);
        int                 sent;
        int                 run_len;
        bit                 restart;
        logic signed [15:0] raw;
        logic               start;
        write_reg({REG_GAIN, 2'b00}, 32'(gain));
        write_reg({REG_OFFSET, 2'b00}, 32'(offset));
        steady <= no_gaps;
        sent = 0;
        while (sent < n_items) begin
            // mostly full blocks, some cut short or run on without a restart
            run_len = ($urandom_range(9) == 0) ? $urandom_range(1, 9) : $urandom_range(10, 60);
            restart = ($urandom_range(9) != 0);
            for (int i = 0; i < run_len && sent < n_items; i++) begin
                case ($urandom_range(7))
                    0:       raw = 16'sh7fff;
                    1:       raw = 16'sh8000;
                    2:       raw = 16'(int'($urandom_range(400)) - 200);
                    default: raw = 16'($urandom);
                endcase
                start = (i == 0 && restart) || ($urandom_range(99) < 2);
                send_sample(raw, start);
                sent++;
            end
        end
        wait_idle();
        steady <= 1'b0;
    endtask

    // result check against the oldest expectation
    always @(posedge clk) begin
        t_fir_result want;
        if (rst_n && out_valid && !out_stall) begin
            if (expected_results.size() == 0) begin
                $error("unexpected transfer: filtered %0d clipped %0b", filtered, clipped);
                mismatches++;
            end else begin
                want = expected_results.pop_front();
                if (filtered !== want.filtered) begin
                    $error("filtered: expected %0d, actual %0d", want.filtered, filtered);
                    mismatches++;
                end
                if (clipped !== want.clipped) begin
                    $error("clipped: expected %0b, actual %0b", want.clipped, clipped);
                    mismatches++;
                end
            end
        end
        out_stall <= !steady && ($urandom_range(99) < 14);
    end

    initial begin
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_block_warmup();
        test_zero_divisor();
        test_offset_full_width();
        test_random_blocks(31'd262144, 16'sd0, 1'b0, 220);
        test_random_blocks(31'h7fff_ffff, 16'sd32767, 1'b0, 200);
        test_random_blocks(31'd1, -16'sd32768, 1'b1, 220);
        test_random_blocks(31'd524288, 16'($urandom), 1'b0, 220);
        test_random_blocks(31'($urandom_range(1 << 12, 1 << 22)), 16'($urandom_range(2000)),
                           1'b0, 220);
        test_random_blocks(31'd2, 16'($urandom), 1'b0, 220);
        if (mismatches == 0)
            $display("fir_filter_offset_gain_divide regression: pass");
        else
            $display("fir_filter_offset_gain_divide regression: fail");
        $finish;
    end

    initial begin
        #5_000_000;
        $display("fir_filter_offset_gain_divide regression: fail");
        $finish;
    end

endmodule
